FILE: rtl/core/ddpd_pkg.sv
// ----------------------------------------------------------------------------
// ddpd_pkg
// Shared constants, types and helper functions of the differential-drive
// base PD controller: sine table, divider constants, saturation.
// ----------------------------------------------------------------------------
`default_nettype none

package ddpd_pkg;

  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int DEPTH_LOG2       = $clog2(SINE_TABLE_DEPTH);
  localparam int QTR              = SINE_TABLE_DEPTH / 4;
  localparam int QTR_W            = DEPTH_LOG2 - 2;

  localparam longint Q30_ONE     = 64'sd1073741824;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint PI_Q20      = 64'sd3294199;
  localparam longint TWO_PI_Q20  = 64'sd6588397;
  localparam int     WRAP_STEPS  = 3;

  // heading offset into a positive angle, then index = round(a*depth / 2pi)
  localparam int     ANG_W    = 25;
  localparam int     N_W      = ANG_W + DEPTH_LOG2;
  localparam int     RECIP_W  = N_W - 22;
  localparam int     Q_W      = N_W - 22;
  localparam longint RECIP    = (64'sd1 <<< N_W) / TWO_PI_Q20;
  localparam longint HALF_REV = TWO_PI_Q20 / 2;
  localparam longint RND_R    = HALF_REV * RECIP;

  localparam int NST = 9;

  typedef logic [30:0] trig_t;
  typedef trig_t trig_tab_t [QTR];

  typedef struct packed {
    logic [31:0] trans_pos_gain;
    logic [31:0] trans_vel_gain;
    logic [31:0] rot_pos_gain;
    logic [31:0] rot_vel_gain;
    logic [31:0] inv_double_axle;
  } cfg_t;

  typedef struct packed {
    logic [NST-1:0] en;
    logic [NST-1:0] vld;
  } pipe_ctl_t;

  typedef enum logic [2:0] {
    REG_TRANS_POS = 3'd0,
    REG_TRANS_VEL = 3'd1,
    REG_ROT_POS   = 3'd2,
    REG_ROT_VEL   = 3'd3,
    REG_INV_AXLE  = 3'd4
  } reg_idx_e;

  localparam logic [31:0] RST_TRANS_POS = 32'd199884800;
  localparam logic [31:0] RST_TRANS_VEL = 32'd6684672;
  localparam logic [31:0] RST_ROT_POS   = 32'd15073280;
  localparam logic [31:0] RST_ROT_VEL   = 32'd327680;
  localparam logic [31:0] RST_INV_AXLE  = 32'd163840;

  function automatic longint clamp_unit(input longint v);
    longint r;
    r = v;
    if (v < 0) r = 0;
    if (v > Q30_ONE) r = Q30_ONE;
    return r;
  endfunction

  function automatic longint first_quad_t(input int r);
    longint rem;
    rem = longint'(r) * 4;
    return (rem * HALF_PI_Q30) / SINE_TABLE_DEPTH;
  endfunction

  function automatic longint sin_entry(input int r);
    longint t;
    longint t2;
    longint sa;
    t  = first_quad_t(r);
    t2 = (t * t) >>> 30;
    sa = Q30_ONE;
    sa = Q30_ONE - ((t2 * sa) >>> 30) / 156;
    sa = Q30_ONE - ((t2 * sa) >>> 30) / 110;
    sa = Q30_ONE - ((t2 * sa) >>> 30) / 72;
    sa = Q30_ONE - ((t2 * sa) >>> 30) / 42;
    sa = Q30_ONE - ((t2 * sa) >>> 30) / 20;
    sa = Q30_ONE - ((t2 * sa) >>> 30) / 6;
    return clamp_unit((t * sa) >>> 30);
  endfunction

  function automatic longint cos_entry(input int r);
    longint t;
    longint t2;
    longint ca;
    t  = first_quad_t(r);
    t2 = (t * t) >>> 30;
    ca = Q30_ONE;
    ca = Q30_ONE - ((t2 * ca) >>> 30) / 132;
    ca = Q30_ONE - ((t2 * ca) >>> 30) / 90;
    ca = Q30_ONE - ((t2 * ca) >>> 30) / 56;
    ca = Q30_ONE - ((t2 * ca) >>> 30) / 30;
    ca = Q30_ONE - ((t2 * ca) >>> 30) / 12;
    ca = Q30_ONE - ((t2 * ca) >>> 30) / 2;
    return clamp_unit(ca);
  endfunction

  function automatic trig_tab_t build_sin_tab();
    trig_tab_t tab;
    for (int i = 0; i < QTR; i++) begin
      tab[i] = trig_t'(sin_entry(i));
    end
    return tab;
  endfunction

  function automatic trig_tab_t build_cos_tab();
    trig_tab_t tab;
    for (int i = 0; i < QTR; i++) begin
      tab[i] = trig_t'(cos_entry(i));
    end
    return tab;
  endfunction

  localparam trig_tab_t SIN_TAB = build_sin_tab();
  localparam trig_tab_t COS_TAB = build_cos_tab();

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ddpd_if.sv
// ----------------------------------------------------------------------------
// ddpd_in_if / ddpd_out_if
// Valid/ready channels carrying one sample request and one torque result.
// ----------------------------------------------------------------------------
`default_nettype none

interface ddpd_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] target_x;
  logic signed [23:0] target_y;
  logic signed [23:0] target_heading;
  logic signed [23:0] pos_x;
  logic signed [23:0] pos_y;
  logic signed [23:0] heading;
  logic signed [23:0] vel_x;
  logic signed [23:0] vel_y;
  logic signed [23:0] ang_rate;

  modport source (
    output valid, target_x, target_y, target_heading, pos_x, pos_y, heading,
           vel_x, vel_y, ang_rate,
    input  ready
  );
  modport sink (
    input  valid, target_x, target_y, target_heading, pos_x, pos_y, heading,
           vel_x, vel_y, ang_rate,
    output ready
  );
endinterface

interface ddpd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] left_torque;
  logic signed [31:0] right_torque;

  modport source (output valid, left_torque, right_torque, input ready);
  modport sink (input valid, left_torque, right_torque, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ddpd_cfg.sv
// ----------------------------------------------------------------------------
// ddpd_cfg
// APB register file holding the PD gains and the Jacobian coefficient.
// ----------------------------------------------------------------------------
`default_nettype none

module ddpd_cfg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [4:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output ddpd_pkg::cfg_t     cfg_o
);

  ddpd_pkg::cfg_t     cfg_q;
  ddpd_pkg::reg_idx_e idx;
  logic               wr;

  assign idx    = ddpd_pkg::reg_idx_e'(paddr[4:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trans_pos_gain  <= ddpd_pkg::RST_TRANS_POS;
      cfg_q.trans_vel_gain  <= ddpd_pkg::RST_TRANS_VEL;
      cfg_q.rot_pos_gain    <= ddpd_pkg::RST_ROT_POS;
      cfg_q.rot_vel_gain    <= ddpd_pkg::RST_ROT_VEL;
      cfg_q.inv_double_axle <= ddpd_pkg::RST_INV_AXLE;
    end else if (wr) begin
      case (idx)
        ddpd_pkg::REG_TRANS_POS: cfg_q.trans_pos_gain  <= pwdata;
        ddpd_pkg::REG_TRANS_VEL: cfg_q.trans_vel_gain  <= pwdata;
        ddpd_pkg::REG_ROT_POS:   cfg_q.rot_pos_gain    <= pwdata;
        ddpd_pkg::REG_ROT_VEL:   cfg_q.rot_vel_gain    <= pwdata;
        ddpd_pkg::REG_INV_AXLE:  cfg_q.inv_double_axle <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      ddpd_pkg::REG_TRANS_POS: prdata = cfg_q.trans_pos_gain;
      ddpd_pkg::REG_TRANS_VEL: prdata = cfg_q.trans_vel_gain;
      ddpd_pkg::REG_ROT_POS:   prdata = cfg_q.rot_pos_gain;
      ddpd_pkg::REG_ROT_VEL:   prdata = cfg_q.rot_vel_gain;
      ddpd_pkg::REG_INV_AXLE:  prdata = cfg_q.inv_double_axle;
      default:                 prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/ddpd_sincos.sv
// ----------------------------------------------------------------------------
// ddpd_sincos
// Four-stage sine/cosine: quantize heading to a table step by reciprocal
// multiply with one correction, then quarter-wave table and quadrant fold.
// ----------------------------------------------------------------------------
`default_nettype none

module ddpd_sincos (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ddpd_pkg::pipe_ctl_t ctl_i,
  input  wire logic signed [23:0] heading_i,
  output logic signed [31:0]      sin_o,
  output logic signed [31:0]      cos_o
);

  localparam int L = ddpd_pkg::DEPTH_LOG2;
  localparam int PW = ddpd_pkg::ANG_W + ddpd_pkg::RECIP_W + L + 1;

  localparam logic [ddpd_pkg::RECIP_W-1:0] RecipC =
    ddpd_pkg::RECIP_W'(ddpd_pkg::RECIP);
  localparam logic [PW-1:0] RndC   = PW'(ddpd_pkg::RND_R);
  localparam logic [22:0]   TwoPiC = 23'(ddpd_pkg::TWO_PI_Q20);
  localparam logic [ddpd_pkg::N_W:0] TwoPiW = (ddpd_pkg::N_W + 1)'(ddpd_pkg::TWO_PI_Q20);
  localparam logic [ddpd_pkg::N_W:0] HalfW  = (ddpd_pkg::N_W + 1)'(ddpd_pkg::HALF_REV);
  localparam logic signed [25:0] OffC = 26'(2 * ddpd_pkg::TWO_PI_Q20);

  logic [ddpd_pkg::ANG_W-1:0]                  a1_q, a2_q;
  logic [ddpd_pkg::ANG_W+ddpd_pkg::RECIP_W-1:0] ar1_q;
  logic [ddpd_pkg::Q_W-1:0]                    q2_q;
  logic [ddpd_pkg::Q_W+22:0]                   qd2_q;
  logic [L-1:0]                                idx3_q;
  logic signed [25:0]                          a_s;
  logic [PW-1:0]                               prod;
  logic [ddpd_pkg::Q_W-1:0]                    q0;
  logic [ddpd_pkg::N_W:0]                      n3, r3;
  logic [ddpd_pkg::Q_W-1:0]                    q3;
  logic [1:0]                                  quad;
  logic [ddpd_pkg::QTR_W-1:0]                  rem;
  logic signed [31:0]                          sv, cv;

  assign a_s  = 26'(heading_i) + OffC;
  assign prod = (PW'(ar1_q) << L) + RndC;
  assign q0   = prod[ddpd_pkg::N_W +: ddpd_pkg::Q_W];
  assign n3   = ((ddpd_pkg::N_W + 1)'(a2_q) << L) + HalfW;
  assign r3   = n3 - (ddpd_pkg::N_W + 1)'(qd2_q);
  assign q3   = (r3 >= TwoPiW) ? q2_q + 1'b1 : q2_q;
  assign quad = idx3_q[L-1:L-2];
  assign rem  = idx3_q[L-3:0];
  assign sv   = 32'(ddpd_pkg::SIN_TAB[rem]);
  assign cv   = 32'(ddpd_pkg::COS_TAB[rem]);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[0]) begin
      a1_q  <= a_s[ddpd_pkg::ANG_W-1:0];
      ar1_q <= a_s[ddpd_pkg::ANG_W-1:0] * RecipC;
    end
    if (ctl_i.en[1]) begin
      a2_q  <= a1_q;
      q2_q  <= q0;
      qd2_q <= q0 * TwoPiC;
    end
    if (ctl_i.en[2]) begin
      idx3_q <= q3[L-1:0];
    end
    if (ctl_i.en[3]) begin
      case (quad)
        2'd0:    begin sin_o <= sv;  cos_o <= cv;  end
        2'd1:    begin sin_o <= cv;  cos_o <= -sv; end
        2'd2:    begin sin_o <= -sv; cos_o <= -cv; end
        default: begin sin_o <= -cv; cos_o <= sv;  end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.vld[1] |-> (r3 < (TwoPiW << 1)))
    else $error("step quotient estimate off by more than one");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/diff_drive_base_pd_controller.sv
// ----------------------------------------------------------------------------
// diff_drive_base_pd_controller
// Differential-drive base PD controller: heading projection, translational
// and rotational PD terms, wrap of heading error, wheel torque mix.
//
//  channel  dir  kind        payload
//  in_i     in   valid/ready setpoint, pose, velocity (9 x 24 bit)
//  out_o    out  valid/ready left/right torque (2 x 32 bit)
//  apb      in   APB slave   5 x 32 bit gain registers
//
// Nine register stages, one request per cycle while the output is not stalled.
// Depth is set by the chain sin/cos -> projection multiply -> gain multiply.
// Each stage holds while its successor is full and stalled; bubbles collapse.
// Reset (rst_ni low) clears all valid bits and loads default gains.
// ----------------------------------------------------------------------------
`default_nettype none

module diff_drive_base_pd_controller (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  ddpd_in_if.sink          in_i,
  ddpd_out_if.source       out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int NST = ddpd_pkg::NST;
  localparam logic signed [24:0] PiC    = 25'(ddpd_pkg::PI_Q20);
  localparam logic signed [24:0] TwoPiC = 25'(ddpd_pkg::TWO_PI_Q20);

  ddpd_pkg::cfg_t      cfg;
  ddpd_pkg::pipe_ctl_t ctl;
  logic [NST-1:0]      vld_q;
  logic [NST-1:0]      en;

  logic signed [31:0] sin_c, cos_c;

  logic signed [24:0] ex_q [4];
  logic signed [24:0] ey_q [4];
  logic signed [23:0] vx_q [4];
  logic signed [23:0] vy_q [4];
  logic signed [23:0] w_q  [3];
  logic signed [24:0] err0_q, errw_q [2];
  logic signed [24:0] errw;

  logic signed [57:0] rp_q, rd_q;
  logic signed [56:0] pec_q, pes_q, pvc_q, pvs_q;
  logic signed [31:0] mz_q;
  logic signed [27:0] te_q, ve_q;
  logic signed [64:0] mzi_q;
  logic signed [60:0] kte_q, kve_q;
  logic signed [48:0] p6_q, p7_q;
  logic signed [31:0] fx_q;
  logic signed [31:0] left_q, right_q;

  logic signed [58:0] rdiff;
  logic signed [57:0] tsum, vsum;
  logic signed [61:0] fdiff;
  logic signed [49:0] hl, hr;

  ddpd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  always_comb begin
    en[NST-1] = !vld_q[NST-1] || out_o.ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign ctl        = '{en: en, vld: vld_q};
  assign in_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_i.valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  ddpd_sincos u_sincos (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .heading_i (in_i.heading),
    .sin_o     (sin_c),
    .cos_o     (cos_c)
  );

  always_comb begin
    errw = err0_q;
    for (int i = 0; i < ddpd_pkg::WRAP_STEPS; i++) begin
      if (errw > PiC) errw = errw - TwoPiC;
    end
    for (int i = 0; i < ddpd_pkg::WRAP_STEPS; i++) begin
      if (errw < -PiC) errw = errw + TwoPiC;
    end
  end

  assign rdiff = 59'(rp_q) - 59'(rd_q);
  assign tsum  = 58'(pec_q) + 58'(pes_q);
  assign vsum  = 58'(pvc_q) + 58'(pvs_q);
  assign fdiff = 62'(kte_q) - 62'(kve_q);
  assign hl    = 50'($signed(fx_q[31:1])) - 50'(p7_q);
  assign hr    = 50'($signed(fx_q[31:1])) + 50'(p7_q);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      ex_q[0] <= 25'(in_i.target_x) - 25'(in_i.pos_x);
      ey_q[0] <= 25'(in_i.target_y) - 25'(in_i.pos_y);
      vx_q[0] <= in_i.vel_x;
      vy_q[0] <= in_i.vel_y;
      w_q[0]  <= in_i.ang_rate;
      err0_q  <= 25'(in_i.target_heading) - 25'(in_i.heading);
    end
    for (int k = 1; k < 4; k++) begin
      if (en[k]) begin
        ex_q[k] <= ex_q[k-1];
        ey_q[k] <= ey_q[k-1];
        vx_q[k] <= vx_q[k-1];
        vy_q[k] <= vy_q[k-1];
      end
    end
    if (en[1]) begin
      errw_q[0] <= errw;
      w_q[1]    <= w_q[0];
    end
    if (en[2]) begin
      errw_q[1] <= errw_q[0];
      w_q[2]    <= w_q[1];
    end
    if (en[3]) begin
      rp_q <= 58'($signed({1'b0, cfg.rot_pos_gain}) * errw_q[1]);
      rd_q <= 58'($signed({1'b0, cfg.rot_vel_gain}) * w_q[2]);
    end
    if (en[4]) begin
      pec_q <= ex_q[3] * cos_c;
      pes_q <= ey_q[3] * sin_c;
      pvc_q <= 57'(vx_q[3] * cos_c);
      pvs_q <= 57'(vy_q[3] * sin_c);
      mz_q  <= ddpd_pkg::sat32(64'($signed(rdiff[58:20])));
    end
    if (en[5]) begin
      te_q  <= tsum[57:30];
      ve_q  <= vsum[57:30];
      mzi_q <= mz_q * $signed({1'b0, cfg.inv_double_axle});
    end
    if (en[6]) begin
      kte_q <= $signed({1'b0, cfg.trans_pos_gain}) * te_q;
      kve_q <= $signed({1'b0, cfg.trans_vel_gain}) * ve_q;
      p6_q  <= mzi_q[64:16];
    end
    if (en[7]) begin
      fx_q <= ddpd_pkg::sat32(64'($signed(fdiff[61:16])));
      p7_q <= p6_q;
    end
    if (en[8]) begin
      left_q  <= ddpd_pkg::sat32(64'(hl));
      right_q <= ddpd_pkg::sat32(64'(hr));
    end
  end

  assign out_o.valid        = vld_q[NST-1];
  assign out_o.left_torque  = left_q;
  assign out_o.right_torque = right_q;

`ifndef NO_ASSERTIONS
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> vld_q[0])
    else $error("accepted request not captured in first stage");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NST-1] && !out_o.ready) |=> vld_q[NST-1])
    else $error("stalled result dropped");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=>
      $stable({out_o.left_torque, out_o.right_torque}))
    else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

FILE: dv/diff_drive_base_pd_controller_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// diff_drive_base_pd_controller_tb
// Drives pose/setpoint requests through the PD controller and checks every
// wheel torque pair against a fixed-point predictor kept in the bench.
// Gains go through several settings, extremes included, written over APB
// while the pipeline is empty. Both channels idle at random, and one long
// output stall fills the pipeline.
// ----------------------------------------------------------------------------

module diff_drive_base_pd_controller_tb;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 30;
  localparam int HOLD_CYCLES    = 300;

  localparam longint HALF_PI_TRIG = 64'sd1686629713;
  localparam longint ONE_Q30      = 64'sd1073741824;
  localparam longint PI_HEAD      = 64'sd3294199;
  localparam longint TWO_PI_HEAD  = 64'sd6588397;
  localparam longint TABLE_DEPTH  = 64'sd1024;

  typedef struct {
    logic signed [23:0] target_x, target_y, target_heading;
    logic signed [23:0] pos_x, pos_y, heading;
    logic signed [23:0] vel_x, vel_y, ang_rate;
  } sample_t;

  typedef struct {
    logic signed [31:0] left_torque;
    logic signed [31:0] right_torque;
  } torque_t;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  ddpd_in_if  req_if ();
  ddpd_out_if trq_if ();

  diff_drive_base_pd_controller DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (req_if.sink),
    .out_o   (trq_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [31:0] gains [5];
  torque_t torque_q [$];
  int errors;
  int src_idle_pct;
  int snk_idle_pct;
  bit hold_req;
  int hold_cnt;
  int idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint sat_word(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void heading_trig(input longint ang, output longint s_o,
                                       output longint c_o);
    longint sden[6] = '{156, 110, 72, 42, 20, 6};
    longint cden[6] = '{132, 90, 56, 30, 12, 2};
    longint a, idx, u, quad, rem, t, t2, sa, ca, sv, cv;
    a = ang + 2 * TWO_PI_HEAD;
    idx = ((a * TABLE_DEPTH + TWO_PI_HEAD / 2) / TWO_PI_HEAD) % TABLE_DEPTH;
    u = idx * 4;
    quad = (u / TABLE_DEPTH) % 4;
    rem = u % TABLE_DEPTH;
    t = (rem * HALF_PI_TRIG) / TABLE_DEPTH;
    t2 = (t * t) >>> 30;
    sa = ONE_Q30;
    ca = ONE_Q30;
    for (int i = 0; i < 6; i++) sa = ONE_Q30 - ((t2 * sa) >>> 30) / sden[i];
    for (int i = 0; i < 6; i++) ca = ONE_Q30 - ((t2 * ca) >>> 30) / cden[i];
    sv = (t * sa) >>> 30;
    sv = sv < 0 ? 0 : (sv > ONE_Q30 ? ONE_Q30 : sv);
    cv = ca < 0 ? 0 : (ca > ONE_Q30 ? ONE_Q30 : ca);
    case (quad)
      0: begin s_o = sv;  c_o = cv;  end
      1: begin s_o = cv;  c_o = -sv; end
      2: begin s_o = -sv; c_o = -cv; end
      default: begin s_o = -cv; c_o = sv; end
    endcase
  endfunction

  function automatic torque_t wheel_torques(input sample_t r);
    longint s, c, ex, ey, te, ve, fx, err, mz, p, h;
    torque_t o;
    heading_trig(longint'(r.heading), s, c);
    ex = longint'(r.target_x) - longint'(r.pos_x);
    ey = longint'(r.target_y) - longint'(r.pos_y);
    te = (ex * c + ey * s) >>> 30;
    ve = (longint'(r.vel_x) * c + longint'(r.vel_y) * s) >>> 30;
    fx = sat_word((longint'({32'd0, gains[ddpd_pkg::REG_TRANS_POS]}) * te
                 - longint'({32'd0, gains[ddpd_pkg::REG_TRANS_VEL]}) * ve) >>> 16);
    err = longint'(r.target_heading) - longint'(r.heading);
    for (int i = 0; i < 3; i++) if (err > PI_HEAD) err -= TWO_PI_HEAD;
    for (int i = 0; i < 3; i++) if (err < -PI_HEAD) err += TWO_PI_HEAD;
    mz = sat_word((longint'({32'd0, gains[ddpd_pkg::REG_ROT_POS]}) * err
                 - longint'({32'd0, gains[ddpd_pkg::REG_ROT_VEL]})
                   * longint'(r.ang_rate)) >>> 20);
    p = (mz * longint'({32'd0, gains[ddpd_pkg::REG_INV_AXLE]})) >>> 16;
    h = fx >>> 1;
    o.left_torque  = 32'(sat_word(h - p));
    o.right_torque = 32'(sat_word(h + p));
    return o;
  endfunction

  // request capture, torque check and watchdog
  always @(posedge clk_i) begin
    torque_t exp_t;
    bit moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        sample_t r;
        r.target_x = req_if.target_x;
        r.target_y = req_if.target_y;
        r.target_heading = req_if.target_heading;
        r.pos_x = req_if.pos_x;
        r.pos_y = req_if.pos_y;
        r.heading = req_if.heading;
        r.vel_x = req_if.vel_x;
        r.vel_y = req_if.vel_y;
        r.ang_rate = req_if.ang_rate;
        torque_q.push_back(wheel_torques(r));
        moved = 1'b1;
      end
      if (trq_if.valid && trq_if.ready) begin
        moved = 1'b1;
        if (torque_q.size() == 0) begin
          $error("torque result with no request pending");
          errors++;
        end else begin
          exp_t = torque_q.pop_front();
          if (trq_if.left_torque !== exp_t.left_torque) begin
            $error("left_torque exp %0d got %0d", exp_t.left_torque, trq_if.left_torque);
            errors++;
          end
          if (trq_if.right_torque !== exp_t.right_torque) begin
            $error("right_torque exp %0d got %0d", exp_t.right_torque,
                   trq_if.right_torque);
            errors++;
          end
        end
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // torque sink: random stall plus one long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      trq_if.ready <= 1'b0;
    end else if (hold_req && hold_cnt == 0) begin
      hold_cnt <= HOLD_CYCLES;
      hold_req <= 1'b0;
      trq_if.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      trq_if.ready <= 1'b0;
    end else begin
      trq_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  task automatic send_sample(input sample_t r);
    if ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.target_x <= r.target_x;
    req_if.target_y <= r.target_y;
    req_if.target_heading <= r.target_heading;
    req_if.pos_x <= r.pos_x;
    req_if.pos_y <= r.pos_y;
    req_if.heading <= r.heading;
    req_if.vel_x <= r.vel_x;
    req_if.vel_y <= r.vel_y;
    req_if.ang_rate <= r.ang_rate;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (torque_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_gain(input int idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 5'(idx * 4);
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx < 5) gains[idx] = val;
  endtask

  task automatic set_all_gains(input logic [31:0] tp, tv, rp, rv, ia);
    write_gain(ddpd_pkg::REG_TRANS_POS, tp);
    write_gain(ddpd_pkg::REG_TRANS_VEL, tv);
    write_gain(ddpd_pkg::REG_ROT_POS, rp);
    write_gain(ddpd_pkg::REG_ROT_VEL, rv);
    write_gain(ddpd_pkg::REG_INV_AXLE, ia);
  endtask

  function automatic sample_t mk(input int tx, ty, th_t, px, py, th, vx, vy, w);
    sample_t r;
    r.target_x = 24'(tx); r.target_y = 24'(ty); r.target_heading = 24'(th_t);
    r.pos_x = 24'(px); r.pos_y = 24'(py); r.heading = 24'(th);
    r.vel_x = 24'(vx); r.vel_y = 24'(vy); r.ang_rate = 24'(w);
    return r;
  endfunction

  function automatic int rand_field();
    case ($urandom_range(3))
      0: return $urandom_range(65535) - 32768;
      1: return $urandom_range(2000000) - 1000000;
      default: return int'($signed(24'($urandom)));
    endcase
  endfunction

  function automatic sample_t rand_sample();
    return mk(rand_field(), rand_field(), rand_field(), rand_field(), rand_field(),
              rand_field(), rand_field(), rand_field(), rand_field());
  endfunction

  task automatic test_directed();
    int mx, mn;
    mx = 8388607;
    mn = -8388608;
    send_sample(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_sample(mk(mx, mx, mx, mn, mn, mn, mx, mx, mx));
    send_sample(mk(mn, mn, mn, mx, mx, mx, mn, mn, mn));
    send_sample(mk(mx, mx, mn, mn, mn, mx, mn, mn, mx));
    send_sample(mk(65536, 0, 0, 0, 0, 1647099, 0, 65536, 0));
    send_sample(mk(0, 65536, 0, 0, 0, 3294199, 65536, 0, 0));
    send_sample(mk(65536, 65536, 0, 0, 0, -1647099, 0, 0, 0));
    send_sample(mk(65536, -65536, 3294200, 0, 0, 0, 0, 0, 0));
    send_sample(mk(65536, -65536, -3294200, 0, 0, 0, 0, 0, 0));
    send_sample(mk(0, 0, 3294199, 0, 0, -3294199, 0, 0, 1048576));
    send_sample(mk(0, 0, 0, 0, 0, 3217, 0, 0, 0));
    send_sample(mk(0, 0, 0, 0, 0, 3218, 0, 0, 0));
    send_sample(mk(-1, -1, -1, -1, -1, -1, -1, -1, -1));
    send_sample(mk(1, 1, 1, 1, 1, 1, 1, 1, 1));
    drain();
  endtask

  task automatic test_gain_extremes();
    set_all_gains('1, '1, '1, '1, '1);
    write_gain(5, 32'h1234_5678);
    write_gain(7, 32'hdead_beef);
    test_directed();
    for (int i = 0; i < 20; i++) send_sample(rand_sample());
    drain();
    set_all_gains('0, '0, '0, '0, '0);
    for (int i = 0; i < 10; i++) send_sample(rand_sample());
    drain();
  endtask

  task automatic test_random(input int n, input int src_pct, input int snk_pct);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    set_all_gains($urandom, $urandom_range(32'h00ff_ffff), $urandom_range(32'h0fff_ffff),
                  $urandom, $urandom_range(32'h000f_ffff));
    for (int i = 0; i < n; i++) send_sample(rand_sample());
    drain();
  endtask

  task automatic test_backpressure();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_req = 1'b1;
    for (int i = 0; i < 60; i++) send_sample(rand_sample());
    drain();
  endtask

  initial begin
    errors = 0;
    src_idle_pct = 25;
    snk_idle_pct = 52;
    hold_req = 1'b0;
    hold_cnt = 0;
    idle_cycles = 0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_if.valid = 1'b0;
    req_if.target_x = '0;
    req_if.target_y = '0;
    req_if.target_heading = '0;
    req_if.pos_x = '0;
    req_if.pos_y = '0;
    req_if.heading = '0;
    req_if.vel_x = '0;
    req_if.vel_y = '0;
    req_if.ang_rate = '0;
    gains[ddpd_pkg::REG_TRANS_POS] = ddpd_pkg::RST_TRANS_POS;
    gains[ddpd_pkg::REG_TRANS_VEL] = ddpd_pkg::RST_TRANS_VEL;
    gains[ddpd_pkg::REG_ROT_POS] = ddpd_pkg::RST_ROT_POS;
    gains[ddpd_pkg::REG_ROT_VEL] = ddpd_pkg::RST_ROT_VEL;
    gains[ddpd_pkg::REG_INV_AXLE] = ddpd_pkg::RST_INV_AXLE;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    test_directed();
    test_gain_extremes();
    test_random(340, 25, 52);
    test_random(340, 52, 25);
    test_random(340, 0, 0);
    test_backpressure();

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
